### rtl/core/isl_pkg.sv
// Shared constants, codes and controller/datapath interface types for the indexed sequence list.
package isl_pkg;

    localparam int C_DEPTH = 256;
    localparam int C_AW    = $clog2(C_DEPTH);
    localparam int C_CW    = 9;
    localparam int C_DW    = 32;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_READ   = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_BADPOS = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_FETCH,
        S_SHIFT,
        S_PUT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic start_rd;
        logic take_rd;
        logic init_shift;
        logic step;
        logic put;
        logic finish;
    } t_dp_ctl;

    typedef struct packed {
        logic ok;
        t_cmd cmd;
        logic shift_done;
        logic out_free;
    } t_dp_sts;

endpackage

### rtl/core/indexed_sequence_list.sv
// Top level of the indexed sequence list: a packed list of signed 32-bit entries.
// The command channel (i_valid, o_stall) carries one beat per command: insert,
// delete, read or clear, with a position and an insert value. A beat is taken
// at a clock edge with i_valid high and o_stall low. Each command gives exactly
// one result beat on the result channel (o_valid, i_stall) with status, the
// value read or deleted, the entry count after the command and an empty flag.
// One command is worked at a time; o_stall stays high until its result is
// loaded into the output register. An insert at position p shifts the entries
// from p upward by one and then writes its value; a delete reads the entry at
// p and then shifts the entries above it down; a read only reads. The shift
// moves one entry per cycle through the single-port read, single-port write
// entry memory. While a result waits under i_stall, the next command is
// accepted and worked; it holds in its final state until the output register
// frees. Reset empties the list and drops any pending result; entry memory
// contents are not cleared and are never read before being written.
module indexed_sequence_list (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_command,
    input  logic [8:0]         i_position,
    input  logic signed [31:0] i_entry_value,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_read_value,
    output logic [8:0]         o_entry_count,
    output logic               o_list_empty
);

    isl_pkg::t_dp_ctl ctl;
    isl_pkg::t_dp_sts sts;

    isl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_ctl   (ctl)
    );

    isl_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .o_sts         (sts),
        .i_command     (i_command),
        .i_position    (i_position),
        .i_entry_value (i_entry_value),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_read_value  (o_read_value),
        .o_entry_count (o_entry_count),
        .o_list_empty  (o_list_empty)
    );

endmodule

### rtl/core/isl_ctrl.sv
// Controller state machine that sequences each list command through the datapath.
module isl_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  isl_pkg::t_dp_sts i_sts,
    output isl_pkg::t_dp_ctl o_ctl
);

    isl_pkg::t_state r_state;
    isl_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= isl_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        o_stall = (r_state != isl_pkg::S_IDLE);
        unique case (r_state)
            isl_pkg::S_IDLE: begin
                if (i_valid) begin
                    o_ctl.load = 1'b1;
                    n_state    = isl_pkg::S_DECIDE;
                end
            end
            isl_pkg::S_DECIDE: begin
                if (!i_sts.ok) begin
                    n_state = isl_pkg::S_DONE;
                end else begin
                    unique case (i_sts.cmd) inside
                        isl_pkg::CMD_INSERT: begin
                            o_ctl.init_shift = 1'b1;
                            n_state          = isl_pkg::S_SHIFT;
                        end
                        isl_pkg::CMD_DELETE, isl_pkg::CMD_READ: begin
                            o_ctl.start_rd = 1'b1;
                            n_state        = isl_pkg::S_FETCH;
                        end
                        default: begin
                            n_state = isl_pkg::S_DONE;
                        end
                    endcase
                end
            end
            isl_pkg::S_FETCH: begin
                o_ctl.take_rd = 1'b1;
                if (i_sts.cmd == isl_pkg::CMD_DELETE) begin
                    o_ctl.init_shift = 1'b1;
                    n_state          = isl_pkg::S_SHIFT;
                end else begin
                    n_state = isl_pkg::S_DONE;
                end
            end
            isl_pkg::S_SHIFT: begin
                if (i_sts.shift_done) begin
                    if (i_sts.cmd == isl_pkg::CMD_INSERT) begin
                        n_state = isl_pkg::S_PUT;
                    end else begin
                        n_state = isl_pkg::S_DONE;
                    end
                end else begin
                    o_ctl.step = 1'b1;
                end
            end
            isl_pkg::S_PUT: begin
                o_ctl.put = 1'b1;
                n_state   = isl_pkg::S_DONE;
            end
            isl_pkg::S_DONE: begin
                if (i_sts.out_free) begin
                    o_ctl.finish = 1'b1;
                    n_state      = isl_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = isl_pkg::S_IDLE;
            end
        endcase
    end

endmodule

### rtl/core/isl_dpath.sv
// Datapath with the entry memory, count, shift pointer and output register.
module isl_dpath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  isl_pkg::t_dp_ctl          i_ctl,
    output isl_pkg::t_dp_sts          o_sts,
    input  logic [1:0]                i_command,
    input  logic [8:0]                i_position,
    input  logic signed [31:0]        i_entry_value,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [1:0]                o_status,
    output logic signed [31:0]        o_read_value,
    output logic [8:0]                o_entry_count,
    output logic                      o_list_empty
);

    logic [isl_pkg::C_DW-1:0] r_mem [isl_pkg::C_DEPTH];

    isl_pkg::t_cmd            r_cmd;
    isl_pkg::t_status         r_status;
    isl_pkg::t_status         n_status;
    logic [isl_pkg::C_CW-1:0] r_pos;
    logic [isl_pkg::C_DW-1:0] r_val;
    logic [isl_pkg::C_CW-1:0] r_count;
    logic [isl_pkg::C_CW-1:0] n_count;
    logic [isl_pkg::C_CW-1:0] r_ptr;
    logic [isl_pkg::C_DW-1:0] r_rval;
    logic [isl_pkg::C_DW-1:0] r_rd_data;
    logic                     r_wpend;
    logic [isl_pkg::C_AW-1:0] r_waddr;
    logic [isl_pkg::C_AW-1:0] n_waddr;

    logic                     rd_en;
    logic [isl_pkg::C_AW-1:0] rd_addr;
    logic                     wr_en;
    logic [isl_pkg::C_AW-1:0] wr_addr;
    logic [isl_pkg::C_DW-1:0] wr_data;

    logic                     r_o_valid;
    logic [1:0]               r_o_status;
    logic [isl_pkg::C_DW-1:0] r_o_rval;
    logic [isl_pkg::C_CW-1:0] r_o_count;
    logic                     r_o_empty;

    always_comb begin
        n_status = isl_pkg::ST_OK;
        unique case (isl_pkg::t_cmd'(i_command)) inside
            isl_pkg::CMD_INSERT: begin
                if (r_count >= isl_pkg::C_CW'(isl_pkg::C_DEPTH)) begin
                    n_status = isl_pkg::ST_FULL;
                end else if (i_position > r_count) begin
                    n_status = isl_pkg::ST_BADPOS;
                end
            end
            isl_pkg::CMD_DELETE, isl_pkg::CMD_READ: begin
                if (i_position >= r_count) begin
                    n_status = isl_pkg::ST_BADPOS;
                end
            end
            default: begin
                n_status = isl_pkg::ST_OK;
            end
        endcase
    end

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_pos[isl_pkg::C_AW-1:0];
        n_waddr = r_waddr;
        if (i_ctl.start_rd) begin
            rd_en = 1'b1;
        end else if (i_ctl.step) begin
            rd_en = 1'b1;
            if (r_cmd == isl_pkg::CMD_INSERT) begin
                rd_addr = isl_pkg::C_AW'(r_ptr - 1'b1);
                n_waddr = r_ptr[isl_pkg::C_AW-1:0];
            end else begin
                rd_addr = r_ptr[isl_pkg::C_AW-1:0];
                n_waddr = isl_pkg::C_AW'(r_ptr - 1'b1);
            end
        end
    end

    always_comb begin
        wr_en   = r_wpend;
        wr_addr = r_waddr;
        wr_data = r_rd_data;
        if (i_ctl.put) begin
            wr_en   = 1'b1;
            wr_addr = r_pos[isl_pkg::C_AW-1:0];
            wr_data = r_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_comb begin
        n_count = r_count;
        if (r_status == isl_pkg::ST_OK) begin
            unique case (r_cmd)
                isl_pkg::CMD_INSERT: n_count = r_count + 1'b1;
                isl_pkg::CMD_DELETE: n_count = r_count - 1'b1;
                isl_pkg::CMD_READ:   n_count = r_count;
                default:             n_count = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd    <= isl_pkg::t_cmd'(i_command);
            r_pos    <= i_position;
            r_val    <= $unsigned(i_entry_value);
            r_status <= n_status;
        end
        if (i_ctl.load) begin
            r_rval <= '0;
        end else if (i_ctl.take_rd) begin
            r_rval <= r_rd_data;
        end
        if (i_ctl.init_shift) begin
            if (r_cmd == isl_pkg::CMD_INSERT) begin
                r_ptr <= r_count;
            end else begin
                r_ptr <= r_pos + 1'b1;
            end
        end else if (i_ctl.step) begin
            if (r_cmd == isl_pkg::CMD_INSERT) begin
                r_ptr <= r_ptr - 1'b1;
            end else begin
                r_ptr <= r_ptr + 1'b1;
            end
        end
        r_waddr <= n_waddr;
        if (i_ctl.finish) begin
            r_o_status <= r_status;
            r_o_rval   <= r_rval;
            r_o_count  <= n_count;
            r_o_empty  <= (n_count == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_wpend   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_wpend <= i_ctl.step;
            if (i_ctl.finish) begin
                r_count   <= n_count;
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts.ok       = (r_status == isl_pkg::ST_OK);
        o_sts.cmd      = r_cmd;
        o_sts.out_free = !r_o_valid || !i_stall;
        if (r_cmd == isl_pkg::CMD_INSERT) begin
            o_sts.shift_done = (r_ptr <= r_pos);
        end else begin
            o_sts.shift_done = (r_ptr >= r_count);
        end
    end

    assign o_valid       = r_o_valid;
    assign o_status      = r_o_status;
    assign o_read_value  = $signed(r_o_rval);
    assign o_entry_count = r_o_count;
    assign o_list_empty  = r_o_empty;

endmodule
